@@ sv/wrcp_pkg.sv @@
// Shared constants for the RIFF WAV chunk parser: tags, chunk ids, parse phases.
// No dependencies; imported by the parser top level.
`default_nettype none

package wrcp_pkg;

    // Width of the file byte counter.
    localparam int POS_W = 32;

    // Little-endian four-character codes as they arrive in the stream.
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_FMT   = 32'h2074_6D66;
    localparam logic [31:0] ID_DATA  = 32'h6174_6164;

    // Offsets within the file header.
    localparam int RIFF_END_POS = 4;
    localparam int WAVE_POS     = 8;
    localparam int WAVE_END_POS = 12;
    localparam int HDR_LAST_POS = 11;

    // A valid file has at least 44 bytes, so its final byte sits at 43 or later.
    localparam int MIN_LAST_POS = 43;
    localparam int FMT_MIN_SIZE = 16;

    localparam logic [1:0] PHASE_HEADER = 2'd0;
    localparam logic [1:0] PHASE_CHUNK  = 2'd1;
    localparam logic [1:0] PHASE_BODY   = 2'd2;
    localparam logic [1:0] PHASE_PAD    = 2'd3;

    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_FMT   = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;

    localparam logic [15:0] FORMAT_PCM = 16'd1;

    typedef logic [POS_W-1:0] pos_t;

endpackage

`default_nettype wire

@@ sv/wav_riff_chunk_parser_unit.sv @@
// RIFF WAV header parser top level: byte input register, chunk walker, result register.
// Depends on wrcp_pkg for tags, chunk ids and phase codes.
//
// Usage: feed the file one byte per beat on data_byte, with last set on the
// final byte. The block checks the RIFF and WAVE tags, walks the chunk list
// from offset 12, and keeps the fmt fields and the data body offset and size.
// For each beat with last set it returns one result beat: ok and the fields,
// all zero when ok is 0. Beats without last produce no result.
// Throughput is one byte per clock, sustained, unless a final byte waits on
// a stalled result register. Each accepted byte sits in the input register
// until the chunk walker takes it; the walker loads the result register as it
// takes a final byte. The walker logic between the input register and the
// state/result registers is a 32-bit increment, a 32-bit decrement and compares.
// When the receiver stalls, the result register holds its beat; the input
// register keeps taking ordinary bytes, and only a final byte waits for the
// result register to free, which then raises in_stall.
// After each result the parser returns to its reset state, so the next byte
// is offset zero of a new file. Reset clears all control state and empties
// both registers.
`default_nettype none

module wav_riff_chunk_parser_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             ok,
    output logic [15:0]      format_tag,
    output logic [15:0]      channels,
    output logic [31:0]      sample_rate,
    output logic [31:0]      avg_byte_rate,
    output logic [15:0]      block_align,
    output logic [15:0]      sample_bits,
    output logic [31:0]      data_offset,
    output logic [31:0]      data_size
);
    import wrcp_pkg::*;

    // Input register.
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;

    // Parser state.
    pos_t         pos_reg, pos_next;
    logic         ovf_reg, ovf_next;
    logic         tags_reg, tags_next;
    logic [1:0]   phase_reg, phase_next;
    logic [63:0]  hdr_reg, hdr_next;
    logic [2:0]   hdr_cnt_reg, hdr_cnt_next;
    logic [1:0]   kind_reg, kind_next;
    logic [31:0]  remain_reg, remain_next;
    logic         pad_reg, pad_next;
    logic [4:0]   fidx_reg, fidx_next;
    logic [127:0] collect_reg, collect_next;
    logic [127:0] commit_reg, commit_next;
    logic         have_fmt_reg, have_fmt_next;
    logic         seen_reg, seen_next;
    pos_t         body_start_reg, body_start_next;
    pos_t         start_reg, start_next;
    logic [31:0]  len_reg, len_next;

    // Result register.
    logic         out_valid_reg;
    logic         ok_reg;
    logic [15:0]  tag_reg;
    logic [15:0]  chans_reg;
    logic [31:0]  rate_reg;
    logic [31:0]  avg_reg;
    logic [15:0]  align_reg;
    logic [15:0]  bits_reg;
    logic [31:0]  offset_reg;
    logic [31:0]  size_reg;

    logic         out_free;
    logic         s1_fire;
    logic         in_take;

    pos_t         pos_inc;
    logic [63:0]  hdr_full;
    logic [31:0]  new_size;
    logic [31:0]  new_id;
    logic         fin;
    logic [1:0]   fin_kind;
    logic [31:0]  fin_size;
    pos_t         fin_start;
    logic [7:0]   expect_byte;
    logic         verdict;
    logic [15:0]  v_tag;
    logic [15:0]  v_chans;
    logic [31:0]  v_rate;
    logic [15:0]  v_align;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign in_take  = in_valid && !in_stall;

    assign pos_inc  = pos_reg + pos_t'(1);
    assign hdr_full = {s1_byte_reg, hdr_reg[63:8]};
    assign new_id   = hdr_full[31:0];
    assign new_size = hdr_full[63:32];

    always_comb
    begin
        if (pos_reg < pos_t'(RIFF_END_POS))
        begin
            expect_byte = 8'(TAG_RIFF >> {pos_reg[1:0], 3'b000});
        end
        else
        begin
            expect_byte = 8'(TAG_WAVE >> {pos_reg[1:0], 3'b000});
        end
    end

    always_comb
    begin
        pos_next        = pos_reg;
        ovf_next        = ovf_reg;
        tags_next       = tags_reg;
        phase_next      = phase_reg;
        hdr_next        = hdr_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        kind_next       = kind_reg;
        remain_next     = remain_reg;
        pad_next        = pad_reg;
        fidx_next       = fidx_reg;
        collect_next    = collect_reg;
        commit_next     = commit_reg;
        have_fmt_next   = have_fmt_reg;
        seen_next       = seen_reg;
        body_start_next = body_start_reg;
        start_next      = start_reg;
        len_next        = len_reg;
        fin             = 1'b0;
        fin_kind        = kind_reg;
        fin_size        = hdr_reg[63:32];
        fin_start       = body_start_reg;

        case (phase_reg)
            PHASE_HEADER:
            begin
                if ((pos_reg < pos_t'(RIFF_END_POS)) ||
                    ((pos_reg >= pos_t'(WAVE_POS)) && (pos_reg < pos_t'(WAVE_END_POS))))
                begin
                    if (s1_byte_reg != expect_byte)
                    begin
                        tags_next = 1'b0;
                    end
                end
                if (pos_reg >= pos_t'(HDR_LAST_POS))
                begin
                    phase_next   = PHASE_CHUNK;
                    hdr_cnt_next = 3'd0;
                end
            end
            PHASE_CHUNK:
            begin
                hdr_next     = hdr_full;
                hdr_cnt_next = hdr_cnt_reg + 3'd1;
                if (hdr_cnt_reg == 3'd7)
                begin
                    if (new_id == ID_FMT)
                    begin
                        kind_next = KIND_FMT;
                    end
                    else if (new_id == ID_DATA)
                    begin
                        kind_next = KIND_DATA;
                    end
                    else
                    begin
                        kind_next = KIND_OTHER;
                    end
                    remain_next     = new_size;
                    pad_next        = new_size[0];
                    fidx_next       = 5'd0;
                    body_start_next = pos_inc;
                    if (new_size == 32'd0)
                    begin
                        // An empty body finishes on its own header.
                        fin       = 1'b1;
                        fin_kind  = kind_next;
                        fin_size  = new_size;
                        fin_start = pos_inc;
                    end
                    else
                    begin
                        phase_next = PHASE_BODY;
                    end
                end
            end
            PHASE_BODY:
            begin
                if ((kind_reg == KIND_FMT) && !fidx_reg[4])
                begin
                    collect_next[{fidx_reg[3:0], 3'b000} +: 8] = s1_byte_reg;
                    fidx_next = fidx_reg + 5'd1;
                end
                remain_next = remain_reg - 32'd1;
                if (remain_reg == 32'd1)
                begin
                    fin        = 1'b1;
                    phase_next = pad_reg ? PHASE_PAD : PHASE_CHUNK;
                end
            end
            default:
            begin
                phase_next = PHASE_CHUNK;
            end
        endcase

        if (fin)
        begin
            if ((fin_kind == KIND_FMT) && (fin_size >= 32'(FMT_MIN_SIZE)))
            begin
                // A full fmt body has rewritten all sixteen collected bytes.
                commit_next   = collect_next;
                have_fmt_next = 1'b1;
            end
            else if (fin_kind == KIND_DATA)
            begin
                seen_next  = 1'b1;
                start_next = fin_start;
                len_next   = fin_size;
            end
        end

        if (!s1_last_reg)
        begin
            pos_next = pos_inc;
            if (pos_inc == '0)
            begin
                ovf_next = 1'b1;
            end
        end
    end

    assign v_tag   = commit_next[15:0];
    assign v_chans = commit_next[31:16];
    assign v_rate  = commit_next[63:32];
    assign v_align = commit_next[111:96];

    assign verdict = !ovf_reg && (pos_reg >= pos_t'(MIN_LAST_POS)) && tags_next &&
                     have_fmt_next && seen_next && (len_next != 32'd0) &&
                     (v_tag == FORMAT_PCM) && (v_chans != 16'd0) &&
                     (v_rate != 32'd0) && (v_align != 16'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            ovf_reg       <= 1'b0;
            tags_reg      <= 1'b1;
            phase_reg     <= PHASE_HEADER;
            hdr_reg       <= '0;
            hdr_cnt_reg   <= 3'd0;
            kind_reg      <= KIND_OTHER;
            remain_reg    <= '0;
            pad_reg       <= 1'b0;
            fidx_reg      <= 5'd0;
            have_fmt_reg  <= 1'b0;
            seen_reg      <= 1'b0;
        end
        else if (s1_fire && s1_last_reg)
        begin
            // The verdict has been taken, so the next byte opens a new file.
            pos_reg       <= '0;
            ovf_reg       <= 1'b0;
            tags_reg      <= 1'b1;
            phase_reg     <= PHASE_HEADER;
            hdr_reg       <= '0;
            hdr_cnt_reg   <= 3'd0;
            kind_reg      <= KIND_OTHER;
            remain_reg    <= '0;
            pad_reg       <= 1'b0;
            fidx_reg      <= 5'd0;
            have_fmt_reg  <= 1'b0;
            seen_reg      <= 1'b0;
        end
        else if (s1_fire)
        begin
            pos_reg       <= pos_next;
            ovf_reg       <= ovf_next;
            tags_reg      <= tags_next;
            phase_reg     <= phase_next;
            hdr_reg       <= hdr_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            kind_reg      <= kind_next;
            remain_reg    <= remain_next;
            pad_reg       <= pad_next;
            fidx_reg      <= fidx_next;
            have_fmt_reg  <= have_fmt_next;
            seen_reg      <= seen_next;
        end
    end

    // Collected fields are only read once their valid flags say they were filled.
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            collect_reg    <= collect_next;
            commit_reg     <= commit_next;
            body_start_reg <= body_start_next;
            start_reg      <= start_next;
            len_reg        <= len_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_reg)
        begin
            ok_reg     <= verdict;
            tag_reg    <= verdict ? v_tag : 16'd0;
            chans_reg  <= verdict ? v_chans : 16'd0;
            rate_reg   <= verdict ? v_rate : 32'd0;
            avg_reg    <= verdict ? commit_next[95:64] : 32'd0;
            align_reg  <= verdict ? v_align : 16'd0;
            bits_reg   <= verdict ? commit_next[127:112] : 16'd0;
            offset_reg <= verdict ? 32'(start_next) : 32'd0;
            size_reg   <= verdict ? len_next : 32'd0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign ok            = ok_reg;
    assign format_tag    = tag_reg;
    assign channels      = chans_reg;
    assign sample_rate   = rate_reg;
    assign avg_byte_rate = avg_reg;
    assign block_align   = align_reg;
    assign sample_bits   = bits_reg;
    assign data_offset   = offset_reg;
    assign data_size     = size_reg;

endmodule

`default_nettype wire

@@ sv/wrcp_checker.sv @@
// Port-level checks for the RIFF WAV chunk parser, bound to its top level.
// Depends on wrcp_pkg for the PCM format code.
`default_nettype none

module wrcp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        ok,
    input wire logic [15:0] format_tag,
    input wire logic [15:0] channels,
    input wire logic [31:0] sample_rate,
    input wire logic [31:0] avg_byte_rate,
    input wire logic [15:0] block_align,
    input wire logic [15:0] sample_bits,
    input wire logic [31:0] data_offset,
    input wire logic [31:0] data_size
);
    import wrcp_pkg::*;

    // A stalled result beat stays up.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

    // A stalled result beat keeps its verdict, data size and data offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(ok) && $stable(data_size) && $stable(data_offset))
    else $error("result payload changed while stalled");

    // A rejected file reports nothing but zeros.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> format_tag == 16'd0 && channels == 16'd0 &&
            sample_rate == 32'd0 && avg_byte_rate == 32'd0 && block_align == 16'd0 &&
            sample_bits == 16'd0 && data_offset == 32'd0 && data_size == 32'd0)
    else $error("rejected file carries nonzero fields");

    // An accepted file is PCM with usable fields, and its data body follows
    // at least the file header and one chunk header.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ok |-> format_tag == FORMAT_PCM && channels != 16'd0 &&
            sample_rate != 32'd0 && block_align != 16'd0 && data_size != 32'd0 &&
            data_offset >= 32'd20)
    else $error("accepted file breaks the verdict rules");

endmodule

bind wav_riff_chunk_parser_unit wrcp_checker u_wrcp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .ok            (ok),
    .format_tag    (format_tag),
    .channels      (channels),
    .sample_rate   (sample_rate),
    .avg_byte_rate (avg_byte_rate),
    .block_align   (block_align),
    .sample_bits   (sample_bits),
    .data_offset   (data_offset),
    .data_size     (data_size)
);

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for wav_riff_chunk_parser_unit: builds WAV files byte by byte,
// predicts each file's verdict and fields, and checks them against the result beats.
// Depends on wrcp_pkg for tags, chunk ids, phase and kind codes.
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import wrcp_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic       fin;
        logic       drain;
    } beat_t;

    typedef struct packed {
        logic        ok;
        logic [15:0] format_tag;
        logic [15:0] channels;
        logic [31:0] sample_rate;
        logic [31:0] avg_byte_rate;
        logic [15:0] block_align;
        logic [15:0] sample_bits;
        logic [31:0] data_offset;
        logic [31:0] data_size;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'd0;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        ok;
    logic [15:0] format_tag;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [31:0] avg_byte_rate;
    logic [15:0] block_align;
    logic [15:0] sample_bits;
    logic [31:0] data_offset;
    logic [31:0] data_size;

    wav_riff_chunk_parser_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .last          (last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .ok            (ok),
        .format_tag    (format_tag),
        .channels      (channels),
        .sample_rate   (sample_rate),
        .avg_byte_rate (avg_byte_rate),
        .block_align   (block_align),
        .sample_bits   (sample_bits),
        .data_offset   (data_offset),
        .data_size     (data_size)
    );

    always #6 clk = ~clk;

    beat_t      byte_feed[$];
    verdict_t   verdicts[$];
    logic [7:0] file_buf[$];
    int         files_queued = 0;
    int         mismatches = 0;

    // Parser image kept by the testbench.
    logic [31:0]  walk_pos;
    logic         walk_ovf;
    logic         tags_ok;
    logic [1:0]   phase;
    logic [63:0]  hdr_shift;
    int           hdr_count;
    logic [1:0]   kind;
    logic [31:0]  body_left;
    logic         pad_due;
    logic [127:0] fmt_bytes;
    logic [127:0] fmt_kept;
    logic         fmt_valid;
    logic         data_valid;
    logic [31:0]  data_at;
    logic [31:0]  data_len;

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    // Mostly back-to-back, often a short gap, now and then a long pause.
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    task automatic parser_clear();
        walk_pos   = '0;
        walk_ovf   = 1'b0;
        tags_ok    = 1'b1;
        phase      = PHASE_HEADER;
        hdr_shift  = '0;
        hdr_count  = 0;
        kind       = KIND_OTHER;
        body_left  = '0;
        pad_due    = 1'b0;
        fmt_bytes  = '0;
        fmt_kept   = '0;
        fmt_valid  = 1'b0;
        data_valid = 1'b0;
        data_at    = '0;
        data_len   = '0;
    endtask

    // Runs on the byte that completes a chunk body, or its header when the body is empty.
    task automatic close_chunk();
        logic [31:0] size;
        size = hdr_shift[63:32];
        if (kind == KIND_FMT && size >= FMT_MIN_SIZE) begin
            fmt_kept  = fmt_bytes;
            fmt_valid = 1'b1;
        end
        else if (kind == KIND_DATA) begin
            data_valid = 1'b1;
            data_at    = walk_pos + 32'd1 - size;
            data_len   = size;
        end
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic fin);
        logic [31:0] idx;
        logic [31:0] cid;
        verdict_t    v;
        case (phase)
            PHASE_HEADER:
            begin
                if (walk_pos < RIFF_END_POS) begin
                    if (b != TAG_RIFF[8*walk_pos[1:0] +: 8])
                        tags_ok = 1'b0;
                end
                else if (walk_pos >= WAVE_POS && walk_pos < WAVE_END_POS) begin
                    if (b != TAG_WAVE[8*walk_pos[1:0] +: 8])
                        tags_ok = 1'b0;
                end
                if (walk_pos >= HDR_LAST_POS) begin
                    phase     = PHASE_CHUNK;
                    hdr_count = 0;
                end
            end
            PHASE_CHUNK:
            begin
                hdr_shift = {b, hdr_shift[63:8]};
                hdr_count++;
                if (hdr_count >= 8) begin
                    cid       = hdr_shift[31:0];
                    hdr_count = 0;
                    kind      = (cid == ID_FMT) ? KIND_FMT :
                                (cid == ID_DATA) ? KIND_DATA : KIND_OTHER;
                    body_left = hdr_shift[63:32];
                    pad_due   = hdr_shift[32];
                    if (hdr_shift[63:32] == 32'd0)
                        close_chunk();
                    else
                        phase = PHASE_BODY;
                end
            end
            PHASE_BODY:
            begin
                idx = hdr_shift[63:32] - body_left;
                if (kind == KIND_FMT && idx < FMT_MIN_SIZE)
                    fmt_bytes[8*idx[3:0] +: 8] = b;
                body_left--;
                if (body_left == 32'd0) begin
                    close_chunk();
                    phase = pad_due ? PHASE_PAD : PHASE_CHUNK;
                end
            end
            default:
                phase = PHASE_CHUNK;
        endcase

        if (!fin) begin
            walk_pos++;
            if (walk_pos == 32'd0)
                walk_ovf = 1'b1;
        end
        else begin
            v = '0;
            if (!walk_ovf && walk_pos >= MIN_LAST_POS && tags_ok && fmt_valid && data_valid &&
                data_len != 32'd0 && fmt_kept[15:0] == FORMAT_PCM && fmt_kept[31:16] != 16'd0 &&
                fmt_kept[63:32] != 32'd0 && fmt_kept[111:96] != 16'd0) begin
                v.ok            = 1'b1;
                v.format_tag    = fmt_kept[15:0];
                v.channels      = fmt_kept[31:16];
                v.sample_rate   = fmt_kept[63:32];
                v.avg_byte_rate = fmt_kept[95:64];
                v.block_align   = fmt_kept[111:96];
                v.sample_bits   = fmt_kept[127:112];
                v.data_offset   = data_at;
                v.data_size     = data_len;
            end
            verdicts = {verdicts, v};
            parser_clear();
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatches++;
        end
    endtask

    // File assembly.

    task automatic put_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++)
            file_buf = {file_buf, v[8*i +: 8]};
    endtask

    task automatic put_riff(input bit bad_riff, input bit bad_wave);
        put_le(bad_riff ? TAG_RIFF ^ (32'h1 << $urandom_range(0, 31)) : TAG_RIFF, 4);
        put_le($urandom, 4);
        put_le(bad_wave ? TAG_WAVE ^ (32'h1 << $urandom_range(0, 31)) : TAG_WAVE, 4);
    endtask

    // A count below zero or not under the size writes the body and any pad; a smaller one cuts it.
    task automatic put_chunk(input logic [31:0] id, input logic [31:0] size, input int body_n);
        int n;
        put_le(id, 4);
        put_le(size, 4);
        n = (body_n < 0 || body_n > size) ? int'(size) : body_n;
        repeat (n)
            file_buf = {file_buf, rand_byte()};
        if (n == size && size[0])
            file_buf = {file_buf, rand_byte()};
    endtask

    task automatic put_fmt(input int sz, input logic [15:0] tag, input logic [15:0] chans,
                           input logic [31:0] rate, input logic [31:0] avg,
                           input logic [15:0] align, input logic [15:0] bits);
        logic [127:0] fields;
        fields = {bits, align, avg, rate, chans, tag};
        put_le(ID_FMT, 4);
        put_le(sz, 4);
        for (int i = 0; i < sz; i++)
            file_buf = {file_buf, (i < 16) ? fields[8*i +: 8] : rand_byte()};
        if (sz % 2 != 0)
            file_buf = {file_buf, rand_byte()};
    endtask

    // Queues the assembled file, cut to keep bytes when keep is positive and short enough.
    task automatic send_file(input int keep, input bit drain);
        int    n;
        beat_t bt;
        n = file_buf.size();
        if (keep > 0 && keep < n)
            n = keep;
        for (int i = 0; i < n; i++) begin
            bt.value = file_buf[i];
            bt.fin   = (i == n - 1);
            bt.drain = drain && (i == 0);
            byte_feed = {byte_feed, bt};
        end
        file_buf.delete();
        files_queued++;
    endtask

    task automatic random_fmt();
        int          r;
        int          sz;
        logic [15:0] tag;
        logic [15:0] chans;
        logic [15:0] align;
        logic [31:0] rate;
        r     = $urandom_range(0, 99);
        sz    = (r < 80) ? 16 : (r < 90) ? $urandom_range(17, 20) : $urandom_range(0, 15);
        tag   = ($urandom_range(0, 99) < 85) ? FORMAT_PCM : 16'($urandom);
        r     = $urandom_range(0, 99);
        chans = (r < 90) ? 16'($urandom_range(1, 8)) : (r < 95) ? 16'd0 : 16'($urandom);
        rate  = ($urandom_range(0, 99) < 95) ? $urandom : 32'd0;
        align = ($urandom_range(0, 99) < 93) ? 16'($urandom_range(1, 65535)) : 16'd0;
        put_fmt(sz, tag, chans, rate, $urandom, align, 16'($urandom));
    endtask

    task automatic random_data();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            put_chunk(ID_DATA, $urandom_range(1, 12), -1);
        else if (r < 87)
            put_chunk(ID_DATA, 32'd0, -1);
        else
            put_chunk(ID_DATA, $urandom, $urandom_range(0, 6));
    endtask

    task automatic random_file();
        int r;
        int keep;
        keep = 0;
        if ($urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(1, 20))
                file_buf = {file_buf, rand_byte()};
        end
        else begin
            put_riff($urandom_range(0, 99) < 4, $urandom_range(0, 99) < 4);
            repeat ($urandom_range(0, 2))
                put_chunk($urandom, $urandom_range(0, 5), -1);
            if ($urandom_range(0, 99) < 85) begin
                random_fmt();
                random_data();
            end
            else begin
                random_data();
                random_fmt();
            end
            r = $urandom_range(0, 99);
            if (r < 5)
                random_fmt();
            else if (r < 10)
                random_data();
            else if (r < 15)
                put_chunk($urandom, $urandom_range(0, 5), -1);
            if ($urandom_range(0, 99) < 10) begin
                repeat ($urandom_range(1, 8))
                    file_buf = {file_buf, rand_byte()};
            end
            if ($urandom_range(0, 99) < 12)
                keep = $urandom_range(1, file_buf.size());
        end
        send_file(keep, $urandom_range(0, 99) < 8);
    endtask

    // Sender: a new beat goes out only after the current one was taken.
    logic  beat_taken = 1'b0;
    int    gap_left = 0;
    int    calm_left = 0;
    beat_t next_beat;

    always @(negedge clk)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || beat_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (byte_feed.size() != 0 && !(byte_feed[0].drain && verdicts.size() != 0)) begin
                next_beat = byte_feed.pop_front();
                data_byte <= next_beat.value;
                last      <= next_beat.fin;
                in_valid  <= 1'b1;
                if (calm_left > 0) begin
                    calm_left--;
                    gap_left = 0;
                end
                else if ($urandom_range(0, 99) < 2) begin
                    calm_left = $urandom_range(40, 150);
                    gap_left  = 0;
                end
                else begin
                    gap_left = idle_span();
                end
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stalls.
    int hold_left = 0;
    int quiet_left = 0;

    always @(negedge clk)
    begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= 1'b0;
            if (quiet_left > 0)
                quiet_left--;
            else if ($urandom_range(0, 99) < 3)
                quiet_left = $urandom_range(30, 150);
            else if ($urandom_range(0, 99) < 30)
                hold_left = idle_span();
        end
    end

    // Result checking first, then the byte taken at this edge goes into the prediction.
    verdict_t result_want;

    always @(posedge clk)
    begin
        if (rst_n) begin
            beat_taken = in_valid && !in_stall;
            if (out_valid && !out_stall) begin
                if (verdicts.size() == 0) begin
                    $error("result beat arrived with no file pending");
                    mismatches++;
                end
                else begin
                    result_want = verdicts.pop_front();
                    check_field("ok", 32'(result_want.ok), 32'(ok));
                    check_field("format_tag", 32'(result_want.format_tag), 32'(format_tag));
                    check_field("channels", 32'(result_want.channels), 32'(channels));
                    check_field("sample_rate", result_want.sample_rate, sample_rate);
                    check_field("avg_byte_rate", result_want.avg_byte_rate, avg_byte_rate);
                    check_field("block_align", 32'(result_want.block_align), 32'(block_align));
                    check_field("sample_bits", 32'(result_want.sample_bits), 32'(sample_bits));
                    check_field("data_offset", result_want.data_offset, data_offset);
                    check_field("data_size", result_want.data_size, data_size);
                end
            end
            if (beat_taken)
                absorb_byte(data_byte, last);
        end
    end

    initial
    begin
        #8_000_000;
        $display("FAIL wav_riff_chunk_parser_unit");
        $finish;
    end

    initial
    begin
        parser_clear();

        // Smallest well-formed file, with its pad byte.
        put_riff(1'b0, 1'b0);
        put_fmt(16, FORMAT_PCM, 16'd1, 32'd8000, 32'd8000, 16'd1, 16'd8);
        put_chunk(ID_DATA, 32'd1, -1);
        send_file(0, 1'b1);
        // Every format field but the tag at its top value; the sender waits for the previous verdict.
        put_riff(1'b0, 1'b0);
        put_fmt(16, FORMAT_PCM, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        put_chunk(ID_DATA, 32'd2, -1);
        send_file(0, 1'b1);
        // Broken RIFF tag, then broken WAVE tag.
        for (int i = 0; i < 2; i++) begin
            put_riff(i == 0, i == 1);
            put_fmt(16, FORMAT_PCM, 16'd2, 32'd44100, 32'd176400, 16'd4, 16'd16);
            put_chunk(ID_DATA, 32'd4, -1);
            send_file(0, 1'b0);
        end
        // Format tag other than PCM.
        put_riff(1'b0, 1'b0);
        put_fmt(16, 16'hFFFE, 16'd2, 32'd44100, 32'd176400, 16'd4, 16'd16);
        put_chunk(ID_DATA, 32'd4, -1);
        send_file(0, 1'b0);
        // Zero channels, zero sample rate, zero block alignment.
        put_riff(1'b0, 1'b0);
        put_fmt(16, FORMAT_PCM, 16'd0, 32'd44100, 32'd176400, 16'd4, 16'd16);
        put_chunk(ID_DATA, 32'd4, -1);
        send_file(0, 1'b0);
        put_riff(1'b0, 1'b0);
        put_fmt(16, FORMAT_PCM, 16'd2, 32'd0, 32'd176400, 16'd4, 16'd16);
        put_chunk(ID_DATA, 32'd4, -1);
        send_file(0, 1'b0);
        put_riff(1'b0, 1'b0);
        put_fmt(16, FORMAT_PCM, 16'd2, 32'd44100, 32'd176400, 16'd0, 16'd16);
        put_chunk(ID_DATA, 32'd4, -1);
        send_file(0, 1'b1);
        // A short fmt chunk alone is skipped.
        put_riff(1'b0, 1'b0);
        put_fmt(14, FORMAT_PCM, 16'd2, 32'd44100, 32'd176400, 16'd4, 16'd16);
        put_chunk(ID_DATA, 32'd3, -1);
        send_file(0, 1'b0);
        // A good fmt survives a later short one; an odd unknown chunk is padded.
        put_riff(1'b0, 1'b0);
        put_fmt(16, FORMAT_PCM, 16'd2, 32'd44100, 32'd176400, 16'd4, 16'd16);
        put_fmt(15, FORMAT_PCM, 16'd0, 32'd0, 32'd0, 16'd0, 16'd0);
        put_chunk(32'h5453_494C, 32'd3, -1);
        put_chunk(ID_DATA, 32'd5, -1);
        send_file(0, 1'b0);
        // An empty data chunk replaces the earlier one.
        put_riff(1'b0, 1'b0);
        put_fmt(16, FORMAT_PCM, 16'd2, 32'd44100, 32'd176400, 16'd4, 16'd16);
        put_chunk(ID_DATA, 32'd4, -1);
        put_chunk(ID_DATA, 32'd0, -1);
        send_file(0, 1'b0);
        // Empty data chunk, then a real one, both ahead of the fmt chunk.
        put_riff(1'b0, 1'b0);
        put_chunk(ID_DATA, 32'd0, -1);
        put_chunk(ID_DATA, 32'd3, -1);
        put_fmt(16, FORMAT_PCM, 16'd1, 32'd22050, 32'd22050, 16'd1, 16'd8);
        send_file(0, 1'b0);
        // A data chunk cut off by the end of file leaves the earlier one standing.
        put_riff(1'b0, 1'b0);
        put_fmt(16, FORMAT_PCM, 16'd2, 32'd48000, 32'd192000, 16'd4, 16'd16);
        put_chunk(ID_DATA, 32'd6, -1);
        put_chunk(ID_DATA, 32'hFFFF_FFFF, 3);
        send_file(0, 1'b0);
        // End of file inside the fmt chunk header.
        put_riff(1'b0, 1'b0);
        put_fmt(16, FORMAT_PCM, 16'd2, 32'd44100, 32'd176400, 16'd4, 16'd16);
        put_chunk(ID_DATA, 32'd2, -1);
        send_file(16, 1'b0);
        // One-byte files.
        file_buf = {file_buf, 8'hFF};
        send_file(0, 1'b0);
        file_buf = {file_buf, 8'h00};
        send_file(0, 1'b0);
        // Shortest file that can pass: the odd data byte ends it, no pad.
        put_riff(1'b0, 1'b0);
        put_fmt(16, FORMAT_PCM, 16'd1, 32'd8000, 32'd8000, 16'd1, 16'd8);
        put_chunk(ID_DATA, 32'd1, -1);
        send_file(45, 1'b0);

        while (byte_feed.size() < 1450 || files_queued < 25)
            random_file();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (byte_feed.size() != 0 || in_valid);
        while (verdicts.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("PASS wav_riff_chunk_parser_unit");
        else
            $display("FAIL wav_riff_chunk_parser_unit");
        $finish;
    end

endmodule

`default_nettype wire

@@ wav_riff_chunk_parser_unit.f @@
sv/wrcp_pkg.sv
sv/wav_riff_chunk_parser_unit.sv
sv/wrcp_checker.sv
sim/tb_top.sv
